FILE: hdl/gpio_rb_pkg.sv
// Shared types, register map constants and access decode for the GPIO register block.
package gpio_rb_pkg;

    // Pin field width on the stream ports and default pin count
    localparam int IO_PINS         = 54;
    localparam int PIN_COUNT_DEF   = 54;

    localparam int DATA_W          = 32;
    localparam int OFFSET_W        = 6;

    // Function-select layout
    localparam int FSEL_WORDS      = 6;
    localparam int PINS_PER_FSEL   = 10;
    localparam int FSEL_BITS       = 3;
    localparam int FSEL_W          = PINS_PER_FSEL * FSEL_BITS;
    localparam int FSEL_IDX_W      = $clog2(FSEL_WORDS);

    // Word offsets
    localparam logic [OFFSET_W-1:0] OFF_SET0    = 6'd7;
    localparam logic [OFFSET_W-1:0] OFF_SET1    = 6'd8;
    localparam logic [OFFSET_W-1:0] OFF_CLR0    = 6'd10;
    localparam logic [OFFSET_W-1:0] OFF_CLR1    = 6'd11;
    localparam logic [OFFSET_W-1:0] OFF_LEV0    = 6'd13;
    localparam logic [OFFSET_W-1:0] OFF_LEV1    = 6'd14;
    localparam logic [OFFSET_W-1:0] OFF_PUD     = 6'd37;
    localparam logic [OFFSET_W-1:0] OFF_PUDCLK0 = 6'd38;
    localparam logic [OFFSET_W-1:0] OFF_PUDCLK1 = 6'd39;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Function and pull codes
    localparam logic [FSEL_BITS-1:0] FUNC_OUTPUT = 3'd1;
    localparam logic [1:0]           PULL_DOWN   = 2'd1;
    localparam logic [1:0]           PULL_UP     = 2'd2;

    typedef enum logic [2:0] {
        RGN_FSEL,
        RGN_SET,
        RGN_CLR,
        RGN_LEV,
        RGN_PUD,
        RGN_PUDCLK,
        RGN_RSVD
    } region_t;

    typedef struct packed {
        region_t region;
        logic    upper;     // second word of a pair: pins 32 and up
    } acc_dec_t;

    // Command from the controller to the datapath
    typedef struct packed {
        logic exec;         // perform the access and load the result word
    } dp_cmd_t;

    // Result word as held by the datapath
    typedef struct packed {
        logic [IO_PINS-1:0] pull_down_on;
        logic [IO_PINS-1:0] pull_up_on;
        logic [IO_PINS-1:0] drive_enable;
        logic [IO_PINS-1:0] drive_level;
        logic               bad_offset;
        logic [DATA_W-1:0]  read_data;
    } dp_result_t;

    function automatic acc_dec_t decode_offset(input logic [OFFSET_W-1:0] off);
        acc_dec_t d;
        d.upper  = 1'b0;
        d.region = RGN_RSVD;
        if (off < OFFSET_W'(FSEL_WORDS))
        begin
            d.region = RGN_FSEL;
        end
        else if (off == OFF_SET0 || off == OFF_SET1)
        begin
            d.region = RGN_SET;
            d.upper  = (off == OFF_SET1);
        end
        else if (off == OFF_CLR0 || off == OFF_CLR1)
        begin
            d.region = RGN_CLR;
            d.upper  = (off == OFF_CLR1);
        end
        else if (off == OFF_LEV0 || off == OFF_LEV1)
        begin
            d.region = RGN_LEV;
            d.upper  = (off == OFF_LEV1);
        end
        else if (off == OFF_PUD)
        begin
            d.region = RGN_PUD;
        end
        else if (off == OFF_PUDCLK0 || off == OFF_PUDCLK1)
        begin
            d.region = RGN_PUDCLK;
            d.upper  = (off == OFF_PUDCLK1);
        end
        return d;
    endfunction

endpackage

FILE: hdl/gpio_register_block_top.sv
// Top level of the GPIO register block: stream ports, controller and datapath.
//
//  channel | dir | tdata (low bit up)                           | tuser
//  --------+-----+----------------------------------------------+------------
//  s_*     | in  | word_offset[5:0], write_data[31:0],          | op (0 rd,
//          |     | pad_levels[53:0], 4 zero pad bits            |     1 wr)
//  m_*     | out | read_data[31:0], drive_level, drive_enable,  | bad_offset
//          |     | pull_up_on, pull_down_on (54 bits each)      |
//
// One access word per clock unless the result side stalls: a word accepted at one
// edge has its result word in the output register from the next cycle, and the input
// side takes the next word in that same cycle; every register update is per-bit logic.
// Reset (rst_n low, asynchronous) clears the function codes, the output latch, the pull
// code and every pin's pull state, and empties the result slot.
// A stalled result word (m_tready low) holds s_tready low until it is taken.
module gpio_register_block_top
    import gpio_rb_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // word_offset, write_data, pad_levels, zero pad
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [247:0] m_tdata,   // read_data, drive_level, drive_enable, pull_up_on,
                                    // pull_down_on
    output logic         m_tuser    // bad_offset
);

    dp_cmd_t    cmd;
    dp_result_t result;

    // Unpack the access word
    logic [OFFSET_W-1:0] word_offset;
    logic [DATA_W-1:0]   write_data;
    logic [IO_PINS-1:0]  pad_levels;

    assign word_offset = s_tdata[5:0];
    assign write_data  = s_tdata[37:6];
    assign pad_levels  = s_tdata[91:38];

    gpio_rb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    gpio_rb_dp #(
        .PIN_COUNT (PIN_COUNT)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (s_tuser),
        .word_offset (word_offset),
        .write_data  (write_data),
        .pad_levels  (pad_levels),
        .result      (result)
    );

    // Pack the result word, lowest field first
    assign m_tdata[31:0]    = result.read_data;
    assign m_tdata[85:32]   = result.drive_level;
    assign m_tdata[139:86]  = result.drive_enable;
    assign m_tdata[193:140] = result.pull_up_on;
    assign m_tdata[247:194] = result.pull_down_on;
    assign m_tuser          = result.bad_offset;

endmodule

FILE: hdl/gpio_rb_ctrl.sv
// Handshake controller: accepts an access word and holds the result word until taken.
module gpio_rb_ctrl
    import gpio_rb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Take a new word whenever the result slot is free or is being emptied now
    assign s_tready = (state_reg == ST_EMPTY) || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_FULL);
    assign cmd.exec = accept;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
            begin
                if (accept)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (!accept && m_tready)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while result slot free");

    a_exec_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> m_tvalid)
        else $error("accepted access produced no result word");

endmodule

FILE: hdl/gpio_rb_dp.sv
// Register file, pin state and result register of the GPIO register block.
module gpio_rb_dp
    import gpio_rb_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic                op,
    input  logic [OFFSET_W-1:0] word_offset,
    input  logic [DATA_W-1:0]   write_data,
    input  logic [IO_PINS-1:0]  pad_levels,
    output dp_result_t          result
);

    // Pins that reach the ports; the rest have no visible effect
    localparam int EFF = (PIN_COUNT < IO_PINS) ? PIN_COUNT : IO_PINS;

    logic [FSEL_W-1:0] fsel_reg [FSEL_WORDS];
    logic [FSEL_W-1:0] fsel_next [FSEL_WORDS];
    logic [EFF-1:0]    latch_reg;
    logic [EFF-1:0]    latch_next;
    logic [1:0]        pull_code_reg;
    logic [1:0]        pull_code_next;
    logic [1:0]        pull_state_reg [EFF];
    logic [1:0]        pull_state_next [EFF];
    logic [DATA_W-1:0] read_data_reg;
    logic [DATA_W-1:0] read_data_next;
    logic              bad_reg;
    logic              bad_next;

    acc_dec_t          dec;
    logic              wr;
    logic [63:0]       half_sel;
    logic [EFF-1:0]    pin_sel;
    logic [63:0]       pads_ext;
    logic [FSEL_IDX_W-1:0] fsel_idx;

    logic [EFF-1:0]    enable_pins;
    logic [EFF-1:0]    up_pins;
    logic [EFF-1:0]    down_pins;

    assign dec      = decode_offset(word_offset);
    assign wr       = (op == OP_WRITE);
    assign half_sel = dec.upper ? {write_data, 32'h0} : {32'h0, write_data};
    assign pin_sel  = half_sel[EFF-1:0];
    assign pads_ext = 64'(pad_levels[EFF-1:0]);
    assign fsel_idx = word_offset[FSEL_IDX_W-1:0];

    always_comb
    begin
        fsel_next       = fsel_reg;
        latch_next      = latch_reg;
        pull_code_next  = pull_code_reg;
        pull_state_next = pull_state_reg;
        read_data_next  = '0;
        bad_next        = 1'b0;
        case (dec.region)
            RGN_FSEL:
            begin
                if (wr)
                begin
                    fsel_next[fsel_idx] = write_data[FSEL_W-1:0];
                end
                else
                begin
                    read_data_next = DATA_W'(fsel_reg[fsel_idx]);
                end
            end
            RGN_SET:
            begin
                if (wr)
                begin
                    latch_next = latch_reg | pin_sel;
                end
            end
            RGN_CLR:
            begin
                if (wr)
                begin
                    latch_next = latch_reg & ~pin_sel;
                end
            end
            RGN_LEV:
            begin
                if (!wr)
                begin
                    read_data_next = dec.upper ? pads_ext[63:32] : pads_ext[31:0];
                end
            end
            RGN_PUD:
            begin
                if (wr)
                begin
                    pull_code_next = write_data[1:0];
                end
                else
                begin
                    read_data_next = DATA_W'(pull_code_reg);
                end
            end
            RGN_PUDCLK:
            begin
                if (wr)
                begin
                    for (int n = 0; n < EFF; n++)
                    begin
                        if (pin_sel[n])
                        begin
                            pull_state_next[n] = pull_code_reg;
                        end
                    end
                end
            end
            default:
            begin
                bad_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < FSEL_WORDS; w++)
            begin
                fsel_reg[w] <= '0;
            end
            for (int n = 0; n < EFF; n++)
            begin
                pull_state_reg[n] <= '0;
            end
            latch_reg     <= '0;
            pull_code_reg <= '0;
            read_data_reg <= '0;
            bad_reg       <= 1'b0;
        end
        else if (cmd.exec)
        begin
            fsel_reg       <= fsel_next;
            pull_state_reg <= pull_state_next;
            latch_reg      <= latch_next;
            pull_code_reg  <= pull_code_next;
            read_data_reg  <= read_data_next;
            bad_reg        <= bad_next;
        end
    end

    // Per-pin decode of the stored state
    for (genvar n = 0; n < EFF; n++)
    begin : g_pin
        assign enable_pins[n] = (fsel_reg[n / PINS_PER_FSEL]
                                 [(n % PINS_PER_FSEL) * FSEL_BITS +: FSEL_BITS] == FUNC_OUTPUT);
        assign up_pins[n]     = (pull_state_reg[n] == PULL_UP);
        assign down_pins[n]   = (pull_state_reg[n] == PULL_DOWN);
    end

    assign result.read_data    = read_data_reg;
    assign result.bad_offset   = bad_reg;
    assign result.drive_level  = IO_PINS'(latch_reg);
    assign result.drive_enable = IO_PINS'(enable_pins);
    assign result.pull_up_on   = IO_PINS'(up_pins);
    assign result.pull_down_on = IO_PINS'(down_pins);

    a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && wr) |=> (read_data_reg == '0))
        else $error("write returned nonzero read data");

    a_latch_only_by_set_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && dec.region != RGN_SET && dec.region != RGN_CLR) |=> $stable(latch_reg))
        else $error("output latch changed outside set/clear access");

    a_pull_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (result.pull_up_on & result.pull_down_on) == '0)
        else $error("pin shows pull up and pull down together");

    a_bad_is_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (bad_reg == $past(dec.region == RGN_RSVD)))
        else $error("reserved flag does not match decoded offset");

endmodule

FILE: tb/gpio_register_block_top_tb.sv
// Self-checking testbench for the GPIO register block: directed table, random accesses.
`timescale 1ns / 1ps

module gpio_register_block_top_tb;
    import gpio_rb_pkg::*;

    // Pins the block is built with, and the mask of pins that exist
    localparam int PINS = PIN_COUNT_DEF;
    localparam logic [IO_PINS-1:0] PIN_MASK =
        (PINS >= IO_PINS) ? {IO_PINS{1'b1}} : ((IO_PINS'(1) << PINS) - IO_PINS'(1));

    // Offsets the package does not name: function-select words and reserved holes
    localparam logic [OFFSET_W-1:0] OFF_FSEL0    = 6'd0;
    localparam logic [OFFSET_W-1:0] OFF_FSEL3    = 6'd3;
    localparam logic [OFFSET_W-1:0] OFF_FSEL4    = 6'd4;
    localparam logic [OFFSET_W-1:0] OFF_FSEL5    = 6'd5;
    localparam logic [OFFSET_W-1:0] RSVD_GAP_A   = 6'd6;
    localparam logic [OFFSET_W-1:0] RSVD_SPAN_LO = 6'd15;
    localparam logic [OFFSET_W-1:0] RSVD_TOP_HI  = 6'd63;

    localparam logic [31:0]        ALL32        = 32'hFFFF_FFFF;
    localparam logic [IO_PINS-1:0] PADS_ALL     = {IO_PINS{1'b1}};
    localparam logic [31:0]        FSEL_ALL_OUT = 32'h0924_9249;   // code 1 in every slot

    localparam int N_DIRECTED   = 26;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;

    // One access word as driven on the input stream
    typedef struct packed {
        logic                op;
        logic [OFFSET_W-1:0] off;
        logic [DATA_W-1:0]   data;
        logic [IO_PINS-1:0]  pads;
        bit                  typed;     // rd/bad below are the expected reply
        logic [DATA_W-1:0]   rd;
        logic                bad;
    } access_row_t;

    // One result word, field by field
    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               bad_offset;
        logic [IO_PINS-1:0] drive_level;
        logic [IO_PINS-1:0] drive_enable;
        logic [IO_PINS-1:0] pull_up_on;
        logic [IO_PINS-1:0] pull_down_on;
    } gpio_reply_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;      // word_offset, write_data, pad_levels, zero pad
    logic         s_tuser;      // op
    logic         m_tvalid;
    logic         m_tready;
    logic [247:0] m_tdata;      // read_data, drive_level, drive_enable, pull_up_on,
                                // pull_down_on
    logic         m_tuser;      // bad_offset

    gpio_register_block_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow of the register file, kept in step with every accepted word
    logic [FSEL_W-1:0]  fsel_shadow [FSEL_WORDS];
    logic [IO_PINS-1:0] latch_shadow;
    logic [1:0]         pull_sel_shadow;
    logic [1:0]         pin_pull_shadow [IO_PINS];

    gpio_reply_t replies_due [$];

    // Expected reply typed into the table for the word now on the bus
    bit                row_typed;
    logic [DATA_W-1:0] row_rd;
    logic              row_bad;

    bit no_idle;            // hold both sides busy for a stretch
    int mismatches;
    int cycle_count;
    int n_reads, n_writes, n_reserved, n_checked;

    // Directed table: reset values, pad extremes, every region, reserved holes,
    // write-only and read-only words, wide function-select data, pull code 3
    access_row_t directed_rows [N_DIRECTED] = '{
        '{OP_READ,  OFF_FSEL0,    32'd0,          '0,       1, 32'd0,          1'b0},
        '{OP_READ,  OFF_LEV0,     ALL32,          PADS_ALL, 1, ALL32,          1'b0},
        '{OP_READ,  OFF_LEV1,     32'd0,          PADS_ALL, 1, 32'h003F_FFFF,  1'b0},
        '{OP_READ,  RSVD_TOP_HI,  ALL32,          PADS_ALL, 1, 32'd0,          1'b1},
        '{OP_WRITE, RSVD_GAP_A,   ALL32,          '0,       1, 32'd0,          1'b1},
        '{OP_WRITE, OFF_FSEL0,    ALL32,          '0,       1, 32'd0,          1'b0},
        '{OP_READ,  OFF_FSEL0,    ALL32,          '0,       1, 32'h3FFF_FFFF,  1'b0},
        '{OP_WRITE, OFF_FSEL5,    FSEL_ALL_OUT,   '0,       1, 32'd0,          1'b0},
        '{OP_WRITE, OFF_FSEL4,    FSEL_ALL_OUT,   '0,       0, 32'd0,          1'b0},
        '{OP_WRITE, OFF_SET0,     ALL32,          '0,       1, 32'd0,          1'b0},
        '{OP_WRITE, OFF_SET1,     ALL32,          '0,       1, 32'd0,          1'b0},
        '{OP_READ,  OFF_SET1,     32'd0,          '0,       1, 32'd0,          1'b0},
        '{OP_WRITE, OFF_CLR0,     32'h5555_5555,  '0,       0, 32'd0,          1'b0},
        '{OP_WRITE, OFF_CLR1,     32'h0020_0001,  '0,       0, 32'd0,          1'b0},
        '{OP_WRITE, OFF_PUD,      ALL32,          '0,       0, 32'd0,          1'b0},
        '{OP_READ,  OFF_PUD,      32'd0,          '0,       1, 32'd3,          1'b0},
        '{OP_WRITE, OFF_PUDCLK0,  32'h0000_FFFF,  '0,       0, 32'd0,          1'b0},
        '{OP_WRITE, OFF_PUD,      32'(PULL_UP),   '0,       0, 32'd0,          1'b0},
        '{OP_WRITE, OFF_PUDCLK1,  ALL32,          '0,       0, 32'd0,          1'b0},
        '{OP_WRITE, OFF_PUD,      32'(PULL_DOWN), '0,       0, 32'd0,          1'b0},
        '{OP_WRITE, OFF_PUDCLK0,  32'hFFFF_0000,  '0,       0, 32'd0,          1'b0},
        '{OP_READ,  OFF_PUDCLK1,  32'd0,          '0,       1, 32'd0,          1'b0},
        '{OP_WRITE, OFF_LEV1,     ALL32,          PADS_ALL, 1, 32'd0,          1'b0},
        '{OP_WRITE, OFF_FSEL3,    32'hD234_5678,  '0,       0, 32'd0,          1'b0},
        '{OP_READ,  OFF_FSEL3,    32'd0,          '0,       0, 32'd0,          1'b0},
        '{OP_READ,  RSVD_SPAN_LO, 32'd0,          '0,       1, 32'd0,          1'b1}
    };

    // Widen a half-word write into a pin mask; the upper word covers pins 32 and up
    function automatic logic [IO_PINS-1:0] pin_half(input logic [31:0] data, input logic upper);
        logic [63:0] wide;
        wide = upper ? {data, 32'd0} : {32'd0, data};
        return wide[IO_PINS-1:0] & PIN_MASK;
    endfunction

    // Apply one access to the shadow registers and build the reply it causes
    task automatic gpio_apply_access(input logic op, input logic [OFFSET_W-1:0] off,
                                     input logic [31:0] data, input logic [IO_PINS-1:0] pads,
                                     output gpio_reply_t reply);
        logic [DATA_W-1:0]  rd;
        logic               bad;
        logic [IO_PINS-1:0] pins;
        logic [IO_PINS-1:0] pads_in;
        logic [63:0]        pads_wide;
        int                 w;
        rd = '0;
        bad = 1'b0;
        pads_in = pads & PIN_MASK;
        pads_wide = 64'(pads_in);
        if (off < OFFSET_W'(FSEL_WORDS))
        begin
            // only the low 30 bits are kept; bits 30 and 31 read back as zero
            if (op == OP_WRITE)
                fsel_shadow[off] = data[FSEL_W-1:0];
            else
                rd = DATA_W'(fsel_shadow[off]);
        end
        else
        begin
            case (off)
                OFF_SET0, OFF_SET1:
                begin
                    if (op == OP_WRITE)
                        latch_shadow = latch_shadow | pin_half(data, off == OFF_SET1);
                end
                OFF_CLR0, OFF_CLR1:
                begin
                    if (op == OP_WRITE)
                        latch_shadow = latch_shadow & ~pin_half(data, off == OFF_CLR1);
                end
                OFF_LEV0:
                begin
                    if (op == OP_READ)
                        rd = pads_wide[31:0];
                end
                OFF_LEV1:
                begin
                    if (op == OP_READ)
                        rd = pads_wide[63:32];
                end
                OFF_PUD:
                begin
                    if (op == OP_WRITE)
                        pull_sel_shadow = data[1:0];
                    else
                        rd = DATA_W'(pull_sel_shadow);
                end
                OFF_PUDCLK0, OFF_PUDCLK1:
                begin
                    if (op == OP_WRITE)
                    begin
                        pins = pin_half(data, off == OFF_PUDCLK1);
                        for (int n = 0; n < IO_PINS; n++)
                            if (pins[n])
                                pin_pull_shadow[n] = pull_sel_shadow;
                    end
                end
                default: bad = 1'b1;
            endcase
        end

        latch_shadow = latch_shadow & PIN_MASK;
        reply.read_data    = (op == OP_WRITE) ? '0 : rd;
        reply.bad_offset   = bad;
        reply.drive_level  = latch_shadow;
        reply.drive_enable = '0;
        reply.pull_up_on   = '0;
        reply.pull_down_on = '0;
        for (int n = 0; n < PINS && n < IO_PINS; n++)
        begin
            // pins with no function-select slot never drive
            w = n / PINS_PER_FSEL;
            if (w < FSEL_WORDS &&
                fsel_shadow[w][(n % PINS_PER_FSEL) * FSEL_BITS +: FSEL_BITS] == FUNC_OUTPUT)
                reply.drive_enable[n] = 1'b1;
            reply.pull_up_on[n]   = (pin_pull_shadow[n] == PULL_UP);
            reply.pull_down_on[n] = (pin_pull_shadow[n] == PULL_DOWN);
        end
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Weight the offsets toward live registers; the rest spans the whole space
    function automatic logic [OFFSET_W-1:0] pick_offset();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            return OFFSET_W'($urandom_range(0, FSEL_WORDS - 1));
        if (pick < 40)
            return $urandom_range(0, 1) ? OFF_SET0 : OFF_SET1;
        if (pick < 52)
            return $urandom_range(0, 1) ? OFF_CLR0 : OFF_CLR1;
        if (pick < 60)
            return $urandom_range(0, 1) ? OFF_LEV0 : OFF_LEV1;
        if (pick < 70)
            return OFF_PUD;
        if (pick < 84)
            return $urandom_range(0, 1) ? OFF_PUDCLK0 : OFF_PUDCLK1;
        return OFFSET_W'($urandom_range(0, 63));
    endfunction

    // Random write data; function-select words lean toward the output code
    function automatic logic [31:0] pick_data(input logic [OFFSET_W-1:0] off);
        logic [31:0] d;
        int          pick;
        pick = $urandom_range(0, 9);
        d = $urandom;
        if (pick == 0)
            d = '0;
        else if (pick == 1)
            d = ALL32;
        else if (off < OFFSET_W'(FSEL_WORDS) && pick < 6)
        begin
            for (int s = 0; s < PINS_PER_FSEL; s++)
                if ($urandom_range(0, 1))
                    d[s * FSEL_BITS +: FSEL_BITS] = FUNC_OUTPUT;
        end
        return d;
    endfunction

    function automatic logic [IO_PINS-1:0] pick_pads();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return PADS_ALL;
        return IO_PINS'({$urandom, $urandom});
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // Present one word at a falling edge and hold it until the block takes it;
    // return at the next falling edge so the caller can drive again
    task automatic send_word(input access_row_t row);
        s_tvalid  <= 1'b1;
        s_tuser   <= row.op;
        s_tdata   <= {4'b0, row.pads, row.data, row.off};
        row_typed <= row.typed;
        row_rd    <= row.rd;
        row_bad   <= row.bad;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid for a random gap, unless a busy stretch is on
    task automatic sender_gap();
        int gap;
        gap = no_idle ? 0 : idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Timeout: give up after a generous number of cycles
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("gpio_register_block_top_tb: errors");
        $finish;
    end

    // Result side: stall at random, never while a busy stretch is on
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                stall = 1 + idle_gap();
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // Check every result word against the oldest expectation, then predict for
    // the word accepted at this same edge
    always @(posedge clk)
    begin : scoreboard
        gpio_reply_t want;
        gpio_reply_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result word with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                due = replies_due.pop_front();
                check_field("read_data",    64'(due.read_data),    64'(m_tdata[31:0]));
                check_field("bad_offset",   64'(due.bad_offset),   64'(m_tuser));
                check_field("drive_level",  64'(due.drive_level),  64'(m_tdata[85:32]));
                check_field("drive_enable", 64'(due.drive_enable), 64'(m_tdata[139:86]));
                check_field("pull_up_on",   64'(due.pull_up_on),   64'(m_tdata[193:140]));
                check_field("pull_down_on", 64'(due.pull_down_on), 64'(m_tdata[247:194]));
                n_checked++;
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            gpio_apply_access(s_tuser, s_tdata[5:0], s_tdata[37:6], s_tdata[91:38], want);
            if (row_typed)
            begin
                want.read_data  = row_rd;
                want.bad_offset = row_bad;
            end
            replies_due.push_back(want);
            if (s_tuser == OP_WRITE)
                n_writes++;
            else
                n_reads++;
            if (want.bad_offset)
                n_reserved++;
        end
    end

    initial
    begin
        access_row_t row;

        // Known values on every input from time zero, with reset held low at the start
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_READ;
        m_tready  = 1'b0;
        row_typed = 1'b0;
        row_rd    = '0;
        row_bad   = 1'b0;
        no_idle   = 1'b0;
        mismatches = 0;
        n_reads = 0;
        n_writes = 0;
        n_reserved = 0;
        n_checked = 0;
        latch_shadow = '0;
        pull_sel_shadow = '0;
        for (int w = 0; w < FSEL_WORDS; w++)
            fsel_shadow[w] = '0;
        for (int n = 0; n < IO_PINS; n++)
            pin_pull_shadow[n] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table first
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_word(directed_rows[i]);
            sender_gap();
        end

        // Random accesses; two stretches run with no idling on either side
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 300 && i < 450) || (i >= 900 && i < 980);
            row.op    = ($urandom_range(0, 99) < 55) ? OP_WRITE : OP_READ;
            row.off   = pick_offset();
            row.data  = pick_data(row.off);
            row.pads  = pick_pads();
            row.typed = 1'b0;
            row.rd    = '0;
            row.bad   = 1'b0;
            send_word(row);
            if (i == RANDOM_ITEMS / 2)
            begin
                // hold off until the result side has caught up completely
                s_tvalid <= 1'b0;
                while (replies_due.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            else
            begin
                sender_gap();
            end
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        // Drain, then allow a few more cycles for any stray result word
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d accesses (%0d reads, %0d writes, %0d to reserved offsets)",
                 n_reads + n_writes, n_reads, n_writes, n_reserved);
        $display("compared %0d result words field by field, %0d mismatches",
                 n_checked, mismatches);
        if (mismatches == 0)
            $display("gpio_register_block_top_tb: clean");
        else
            $display("gpio_register_block_top_tb: errors");
        $finish;
    end

endmodule
